// File: design/tmcw_pkg.sv
package tmcw_pkg;

    // default geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STEP = 4;

    // port field widths
    localparam int MODE_W = 2;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;
    localparam int CELL_W = 16;

    localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;

    // space, attribute 0 (attribute in the high byte)
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0020;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_PUT,
        ST_CHECK,
        ST_COPY,
        ST_DRAIN,
        ST_FILL,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic ptr_clr;
        logic ptr_inc;
        logic blank_wr;
        logic copy_rd;
        logic cursor_home;
        logic cursor_step;
        logic cursor_scroll;
        logic result_load;
    } ctl_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              row_full;
        logic              copy_last;
        logic              sweep_last;
        logic              out_free;
    } stat_t;

endpackage

// File: design/tmcw_ctrl.sv
module tmcw_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tmcw_pkg::stat_t stat,
    output tmcw_pkg::ctl_t  ctl
);

    tmcw_pkg::state_t state_reg;
    tmcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tmcw_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tmcw_pkg::ST_INIT:
            begin
                if (stat.sweep_last)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
            end
            tmcw_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tmcw_pkg::ST_DISPATCH;
                end
            end
            tmcw_pkg::ST_DISPATCH:
            begin
                case (stat.mode)
                    tmcw_pkg::MODE_PUT:   state_next = tmcw_pkg::ST_PUT;
                    tmcw_pkg::MODE_CLEAR: state_next = tmcw_pkg::ST_CLEAR;
                    default:              state_next = tmcw_pkg::ST_RESULT;
                endcase
            end
            tmcw_pkg::ST_PUT:
            begin
                state_next = tmcw_pkg::ST_CHECK;
            end
            tmcw_pkg::ST_CHECK:
            begin
                state_next = stat.row_full ? tmcw_pkg::ST_COPY : tmcw_pkg::ST_RESULT;
            end
            tmcw_pkg::ST_COPY:
            begin
                if (stat.copy_last)
                begin
                    state_next = tmcw_pkg::ST_DRAIN;
                end
            end
            tmcw_pkg::ST_DRAIN:
            begin
                state_next = tmcw_pkg::ST_FILL;
            end
            tmcw_pkg::ST_FILL,
            tmcw_pkg::ST_CLEAR:
            begin
                if (stat.sweep_last)
                begin
                    state_next = tmcw_pkg::ST_RESULT;
                end
            end
            tmcw_pkg::ST_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmcw_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_ready = 1'b0;
        case (state_reg)
            tmcw_pkg::ST_INIT,
            tmcw_pkg::ST_CLEAR:
            begin
                ctl.blank_wr = 1'b1;
                ctl.ptr_inc  = 1'b1;
            end
            tmcw_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctl.accept = in_valid;
            end
            tmcw_pkg::ST_DISPATCH:
            begin
                ctl.ptr_clr     = 1'b1;
                ctl.cursor_home = (stat.mode == tmcw_pkg::MODE_CLEAR);
            end
            tmcw_pkg::ST_PUT:
            begin
                ctl.cursor_step = 1'b1;
            end
            tmcw_pkg::ST_COPY:
            begin
                ctl.copy_rd = 1'b1;
                ctl.ptr_inc = 1'b1;
            end
            tmcw_pkg::ST_FILL:
            begin
                ctl.blank_wr      = 1'b1;
                ctl.ptr_inc       = 1'b1;
                ctl.cursor_scroll = stat.sweep_last;
            end
            tmcw_pkg::ST_RESULT:
            begin
                ctl.result_load = stat.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// File: design/tmcw_datapath.sv
module tmcw_datapath #(
    parameter int COLUMNS  = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tmcw_pkg::DEF_ROWS,
    parameter int TAB_STEP = tmcw_pkg::DEF_TAB_STEP
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmcw_pkg::ctl_t                ctl,
    output tmcw_pkg::stat_t               stat,
    input  logic [tmcw_pkg::MODE_W-1:0]   mode,
    input  logic [tmcw_pkg::BYTE_W-1:0]   character,
    input  logic [tmcw_pkg::BYTE_W-1:0]   color,
    input  logic [tmcw_pkg::IDX_W-1:0]    cell_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmcw_pkg::COL_W-1:0]    cursor_col,
    output logic [tmcw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tmcw_pkg::LIN_W-1:0]    cursor_linear,
    output logic [tmcw_pkg::BYTE_W-1:0]   read_char,
    output logic [tmcw_pkg::BYTE_W-1:0]   read_attr
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int PW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int TW    = $clog2(COLUMNS + TAB_STEP);

    logic [tmcw_pkg::CELL_W-1:0] mem [CELLS];

    // request held for the whole step
    logic [tmcw_pkg::MODE_W-1:0] mode_reg;
    logic [tmcw_pkg::BYTE_W-1:0] char_reg;
    logic [tmcw_pkg::BYTE_W-1:0] color_reg;
    logic [tmcw_pkg::IDX_W-1:0]  idx_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] ptr_reg, ptr_next;

    logic                        pend_reg;
    logic [PW-1:0]               pend_addr_reg;
    logic [tmcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                        out_valid_reg;

    logic [tmcw_pkg::COL_W-1:0]  col_out_reg;
    logic [tmcw_pkg::ROW_W-1:0]  row_out_reg;
    logic [tmcw_pkg::LIN_W-1:0]  lin_out_reg;
    logic [tmcw_pkg::BYTE_W-1:0] rchar_out_reg;
    logic [tmcw_pkg::BYTE_W-1:0] rattr_out_reg;

    logic [31:0]   cur_lin;
    logic [PW-1:0] cur_addr;
    logic [31:0]   idx_wide;
    logic          idx_ok;
    logic [PW-1:0] idx_addr;
    logic [PW-1:0] rd_addr;
    logic [TW-1:0] tab_sum;
    logic          is_ctrl_char;
    logic          put_wr;
    logic [15:0]   col_wide;
    logic [15:0]   row_wide;
    logic          show_read;

    assign cur_lin  = 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg);
    assign cur_addr = cur_lin[PW-1:0];
    assign idx_wide = 32'(idx_reg);
    assign idx_ok   = idx_wide < 32'(CELLS);
    assign idx_addr = idx_ok ? idx_wide[PW-1:0] : '0;
    // copy reads one row ahead of where it writes
    assign rd_addr  = ctl.copy_rd ? PW'(32'(ptr_reg) + 32'(COLUMNS)) : idx_addr;
    assign tab_sum  = TW'(col_reg) + TW'(TAB_STEP);

    assign is_ctrl_char = (char_reg == tmcw_pkg::CH_CR) || (char_reg == tmcw_pkg::CH_LF)
                       || (char_reg == tmcw_pkg::CH_TAB);
    assign put_wr = ctl.cursor_step && !is_ctrl_char;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (ctl.cursor_home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (ctl.cursor_scroll)
        begin
            row_next = RW'(ROWS - 1);
        end
        else if (ctl.cursor_step)
        begin
            if ((char_reg == tmcw_pkg::CH_CR) || (char_reg == tmcw_pkg::CH_LF))
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else if (char_reg == tmcw_pkg::CH_TAB)
            begin
                if (tab_sum >= TW'(COLUMNS))
                begin
                    col_next = CW'(tab_sum - TW'(COLUMNS));
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = CW'(tab_sum);
                end
            end
            else if (col_reg == CW'(COLUMNS - 1))
            begin
                col_next = '0;
                row_next = row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctl.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (ctl.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            ptr_reg  <= ptr_next;
            pend_reg <= ctl.copy_rd;
            if (ctl.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            mode_reg  <= mode;
            char_reg  <= character;
            color_reg <= color;
            idx_reg   <= cell_index;
        end
        pend_addr_reg <= ptr_reg;
    end

    // cell memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctl.blank_wr)
        begin
            mem[ptr_reg] <= tmcw_pkg::BLANK_CELL;
        end
        else if (put_wr)
        begin
            mem[cur_addr] <= {color_reg, char_reg};
        end
        else if (pend_reg)
        begin
            mem[pend_addr_reg] <= rd_data_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign col_wide  = 16'(col_reg);
    assign row_wide  = 16'(row_reg);
    assign show_read = (mode_reg == tmcw_pkg::MODE_READ) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (ctl.result_load)
        begin
            col_out_reg   <= col_wide[tmcw_pkg::COL_W-1:0];
            row_out_reg   <= row_wide[tmcw_pkg::ROW_W-1:0];
            lin_out_reg   <= cur_lin[tmcw_pkg::LIN_W-1:0];
            rchar_out_reg <= show_read ? rd_data_reg[7:0] : '0;
            rattr_out_reg <= show_read ? rd_data_reg[15:8] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign cursor_col    = col_out_reg;
    assign cursor_row    = row_out_reg;
    assign cursor_linear = lin_out_reg;
    assign read_char     = rchar_out_reg;
    assign read_attr     = rattr_out_reg;

    assign stat.mode       = mode_reg;
    assign stat.row_full   = (row_reg == RW'(ROWS));
    assign stat.copy_last  = (ptr_reg == PW'(CELLS - COLUMNS - 1));
    assign stat.sweep_last = (ptr_reg == PW'(CELLS - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

endmodule

// File: design/text_mode_console_writer.sv
// channel  | handshake           | payload
// ---------+---------------------+-------------------------------------------------
// request  | in_valid / in_ready | mode, character, color, cell_index
// result   | out_valid/out_ready | cursor_col, cursor_row, cursor_linear,
//          |                     | read_char, read_attr
//
// a put passes the DISPATCH, PUT and CHECK states before its result is loaded, a read or
// an unused mode only DISPATCH; a put that runs off the bottom row scrolls: a cell-by-cell
// copy that reads each cell one row below where it writes, then a blank fill of the last row
// clear screen sweeps the memory once
// after reset a clearing pass over all ROWS*COLUMNS cells runs before in_ready rises
// a result waiting in the output register does not stop the next request being taken
module text_mode_console_writer #(
    parameter int COLUMNS  = tmcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tmcw_pkg::DEF_ROWS,
    parameter int TAB_STEP = tmcw_pkg::DEF_TAB_STEP
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmcw_pkg::MODE_W-1:0]   mode,
    input  logic [tmcw_pkg::BYTE_W-1:0]   character,
    input  logic [tmcw_pkg::BYTE_W-1:0]   color,
    input  logic [tmcw_pkg::IDX_W-1:0]    cell_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tmcw_pkg::COL_W-1:0]    cursor_col,
    output logic [tmcw_pkg::ROW_W-1:0]    cursor_row,
    output logic [tmcw_pkg::LIN_W-1:0]    cursor_linear,
    output logic [tmcw_pkg::BYTE_W-1:0]   read_char,
    output logic [tmcw_pkg::BYTE_W-1:0]   read_attr
);

    tmcw_pkg::ctl_t  ctl;
    tmcw_pkg::stat_t stat;

    tmcw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    tmcw_datapath #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .stat          (stat),
        .mode          (mode),
        .character     (character),
        .color         (color),
        .cell_index    (cell_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cursor_col    (cursor_col),
        .cursor_row    (cursor_row),
        .cursor_linear (cursor_linear),
        .read_char     (read_char),
        .read_attr     (read_attr)
    );

`ifndef ASSERT_OFF
    // cursor is back on screen before a new request can be taken
    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !stat.row_full)
        else $error("cursor row off screen while idle");

    // no request taken while the memory is being swept
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.blank_wr || ctl.copy_rd) |-> !in_ready)
        else $error("request taken during memory sweep");

    // a result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |-> (!out_valid || out_ready))
        else $error("result register overwritten");

    // one request in flight at a time
    a_single_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");
`endif

endmodule
